/* sv/rfgv_pkg.sv */
// Package for the rotating-frame ghost velocity block.
// Types, state codes, field widths and constants shared by controller,
// datapath and top level. No dependencies.
package rfgv_pkg;

   localparam int POINTS_PER_LAYER = 4;
   localparam int NUM_LAYERS       = 3;
   localparam int CELL_POINTS      = NUM_LAYERS * POINTS_PER_LAYER;
   localparam int NUM_AXES         = 3;

   localparam int DATA_W  = 32;  // Q16.16 fields and registers
   localparam int SUM_W   = 35;  // per-layer, per-axis sum
   localparam int N_W     = 37;  // eight times a ghost coordinate
   localparam int MOP_W   = 21;  // multiplier operand taken from N
   localparam int PROD_W  = MOP_W + DATA_W;
   localparam int ACC_W   = 70;  // exact cross-term difference
   localparam int SHR_W   = ACC_W - 19;
   localparam int CNT_W   = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [CNT_W-1:0] LAST_POINT = CNT_W'(CELL_POINTS - 1);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA_Z  = 3'd5;

   // Axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Partial products of one cross term a*b - c*d
   localparam logic [1:0] PART_AB_HI = 2'd0;
   localparam logic [1:0] PART_AB_LO = 2'd1;
   localparam logic [1:0] PART_CD_HI = 2'd2;
   localparam logic [1:0] PART_CD_LO = 2'd3;

   localparam logic signed [ACC_W-1:0] ROUND_BIAS = 70'sh40000;  // 2^18

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LATCH,
      ST_MAC,
      ST_FLUSH_ACC,
      ST_FLUSH_RND,
      ST_EMIT0,
      ST_EMIT1
   } rfgv_state_type;

   typedef struct packed {
      logic       acc_en;
      logic [1:0] acc_layer;
      logic       latch_en;
      logic       mac_en;
      logic       mac_layer;
      logic [1:0] mac_axis;
      logic [1:0] mac_part;
      logic       emit_en;
      logic       emit_layer;
   } rfgv_cmd_type;

endpackage

/* sv/rotating_frame_ghost_velocity.sv */
// Top level of the rotating-frame ghost velocity block.
// Instantiates rfgv_ctrl and rfgv_datapath; depends on rfgv_pkg.
//
//  channel   handshake              payload
//  --------  ---------------------  ----------------------------------------
//  request   start & !busy          req_point_x/y/z (Q16.16)
//  result    rsp_strobe             rsp_ghost_layer, rsp_delta_u/v/w,
//                                   rsp_last_of_cell
//  config    csr_we                 csr_index (0..5), csr_wdata
//
// Cycles: one point request per cycle while busy is low. After the twelfth
// point of a cell the block is busy: it forms the ghost positions, runs the
// single shared 21x32 multiplier (4 partial products for each of 6 cross
// terms), drains accumulate and rounding, and then emits the results.
// Reset: synchronous, clears the point count, layer sums and configuration registers.
// Stalls: the result receiver cannot stall; results go out on consecutive
// cycles, first ghost layer first.
module rotating_frame_ghost_velocity import rfgv_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_point_x,
   input  logic signed [DATA_W-1:0] req_point_y,
   input  logic signed [DATA_W-1:0] req_point_z,
   output logic                     rsp_strobe,
   output logic                     rsp_ghost_layer,
   output logic signed [DATA_W-1:0] rsp_delta_u,
   output logic signed [DATA_W-1:0] rsp_delta_v,
   output logic signed [DATA_W-1:0] rsp_delta_w,
   output logic                     rsp_last_of_cell,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   rfgv_cmd_type cmd;

   // sequencing: point count, multiply steps, result slots
   rfgv_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // arithmetic and storage
   rfgv_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ghost_layer  (rsp_ghost_layer),
      .rsp_delta_u      (rsp_delta_u),
      .rsp_delta_v      (rsp_delta_v),
      .rsp_delta_w      (rsp_delta_w),
      .rsp_last_of_cell (rsp_last_of_cell)
   );

   // results are valid during the two emit slots only
   assign rsp_strobe = cmd.emit_en;

endmodule

/* sv/rfgv_ctrl.sv */
// Controller of the rotating-frame ghost velocity block.
// Counts points of a cell and sequences latch, multiply-accumulate and emit.
// Depends on rfgv_pkg.
module rfgv_ctrl import rfgv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output rfgv_cmd_type cmd
);

   rfgv_state_type   state_ff, state_in;
   logic [CNT_W-1:0] point_count_ff, point_count_in;
   logic             mac_layer_ff, mac_layer_in;
   logic [1:0]       mac_axis_ff, mac_axis_in;
   logic [1:0]       mac_part_ff, mac_part_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= '0;
         mac_layer_ff   <= 1'b0;
         mac_axis_ff    <= AXIS_X;
         mac_part_ff    <= PART_AB_HI;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         mac_layer_ff   <= mac_layer_in;
         mac_axis_ff    <= mac_axis_in;
         mac_part_ff    <= mac_part_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      point_count_in = point_count_ff;
      mac_layer_in   = mac_layer_ff;
      mac_axis_in    = mac_axis_ff;
      mac_part_in    = mac_part_ff;
      busy           = 1'b1;
      cmd            = '0;
      cmd.acc_layer  = point_count_ff[3:2];
      cmd.mac_layer  = mac_layer_ff;
      cmd.mac_axis   = mac_axis_ff;
      cmd.mac_part   = mac_part_ff;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.acc_en = 1'b1;
               if (point_count_ff == LAST_POINT) begin
                  point_count_in = '0;
                  state_in       = ST_LATCH;
               end else begin
                  point_count_in = point_count_ff + CNT_W'(1);
               end
            end
         end
         ST_LATCH: begin
            cmd.latch_en = 1'b1;
            mac_layer_in = 1'b0;
            mac_axis_in  = AXIS_X;
            mac_part_in  = PART_AB_HI;
            state_in     = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_en  = 1'b1;
            mac_part_in = mac_part_ff + 2'd1;
            if (mac_part_ff == PART_CD_LO) begin
               if (mac_axis_ff == AXIS_Z) begin
                  mac_axis_in  = AXIS_X;
                  mac_layer_in = 1'b1;
                  if (mac_layer_ff) begin
                     state_in = ST_FLUSH_ACC;
                  end
               end else begin
                  mac_axis_in = mac_axis_ff + 2'd1;
               end
            end
         end
         ST_FLUSH_ACC: begin
            state_in = ST_FLUSH_RND;
         end
         ST_FLUSH_RND: begin
            state_in = ST_EMIT0;
         end
         ST_EMIT0: begin
            cmd.emit_en    = 1'b1;
            cmd.emit_layer = 1'b0;
            state_in       = ST_EMIT1;
         end
         ST_EMIT1: begin
            cmd.emit_en    = 1'b1;
            cmd.emit_layer = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // second ghost layer is always right behind the first
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_en && cmd.emit_layer) |-> $past(cmd.emit_en && !cmd.emit_layer))
      else $error("second result without first");

   // twelfth point of a cell starts the computation
   a_cell_done: assert property (@(posedge clock) disable iff (reset)
      (!busy && start && point_count_ff == LAST_POINT) |=> (state_ff == ST_LATCH))
      else $error("cell completion missed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      point_count_ff <= LAST_POINT)
      else $error("point count out of range");

   // block frees up only after the last result of a cell
   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> $past(state_ff == ST_EMIT1))
      else $error("busy dropped early");

endmodule

/* sv/rfgv_datapath.sv */
// Datapath of the rotating-frame ghost velocity block: configuration
// registers, layer sums, ghost positions, shared multiplier and rounding.
// Depends on rfgv_pkg; driven by rfgv_ctrl commands.
module rfgv_datapath import rfgv_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  rfgv_cmd_type                cmd,
   input  logic signed [DATA_W-1:0]    req_point_x,
   input  logic signed [DATA_W-1:0]    req_point_y,
   input  logic signed [DATA_W-1:0]    req_point_z,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_wdata,
   output logic                        rsp_ghost_layer,
   output logic signed [DATA_W-1:0]    rsp_delta_u,
   output logic signed [DATA_W-1:0]    rsp_delta_v,
   output logic signed [DATA_W-1:0]    rsp_delta_w,
   output logic                        rsp_last_of_cell
);

   logic signed [DATA_W-1:0] center_ff [NUM_AXES];
   logic signed [DATA_W-1:0] omega_ff  [NUM_AXES];
   logic signed [SUM_W-1:0]  sums_ff   [NUM_LAYERS][NUM_AXES];
   logic signed [N_W-1:0]    n_ff      [2][NUM_AXES];

   logic signed [DATA_W-1:0] point [NUM_AXES];
   logic signed [N_W-1:0]    n1_in [NUM_AXES];
   logic signed [N_W-1:0]    n2_in [NUM_AXES];

   // multiplier stage
   logic [1:0]               ia, ic;
   logic signed [N_W-1:0]    na, nc, nsel;
   logic signed [DATA_W-1:0] wsel;
   logic signed [MOP_W-1:0]  mop;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic                     prod_valid_ff, prod_shift_ff, prod_sub_ff;
   logic                     prod_first_ff, prod_last_ff, prod_layer_ff;
   logic [1:0]               prod_axis_ff;

   // accumulate stage
   logic signed [ACC_W-1:0]  term, acc_base, acc_in, acc_ff;
   logic                     rnd_valid_ff, rnd_layer_ff;
   logic [1:0]               rnd_axis_ff;

   // round and saturate stage
   logic signed [ACC_W-1:0]  biased;
   logic signed [SHR_W-1:0]  shr;
   logic signed [DATA_W-1:0] sat;
   logic signed [DATA_W-1:0] res_ff [2][NUM_AXES];

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   // 8*g1 = 3*S0 - S1 - 8c,  8*g2 = 4*S0 - S1 - S2 - 8c
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         logic signed [N_W-1:0] s0, s1, s2, c8;
         s0 = N_W'(sums_ff[0][a]);
         s1 = N_W'(sums_ff[1][a]);
         s2 = N_W'(sums_ff[2][a]);
         c8 = {{(N_W-DATA_W-3){center_ff[a][DATA_W-1]}}, center_ff[a], 3'b000};
         n1_in[a] = (s0 <<< 1) + s0 - s1 - c8;
         n2_in[a] = (s0 <<< 2) - s1 - s2 - c8;
      end
   end

   // control state and cleared stores
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            center_ff[a] <= '0;
            omega_ff[a]  <= '0;
            for (int l = 0; l < NUM_LAYERS; l++) begin
               sums_ff[l][a] <= '0;
            end
         end
         prod_valid_ff <= 1'b0;
         rnd_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= cmd.mac_en;
         rnd_valid_ff  <= prod_valid_ff && prod_last_ff;
         if (csr_we) begin
            case (csr_index)
               CSR_CENTER_X: center_ff[0] <= csr_wdata;
               CSR_CENTER_Y: center_ff[1] <= csr_wdata;
               CSR_CENTER_Z: center_ff[2] <= csr_wdata;
               CSR_OMEGA_X:  omega_ff[0]  <= csr_wdata;
               CSR_OMEGA_Y:  omega_ff[1]  <= csr_wdata;
               CSR_OMEGA_Z:  omega_ff[2]  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.acc_en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               sums_ff[cmd.acc_layer][a] <= sums_ff[cmd.acc_layer][a] + SUM_W'(point[a]);
            end
         end
         if (cmd.latch_en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               for (int l = 0; l < NUM_LAYERS; l++) begin
                  sums_ff[l][a] <= '0;
               end
            end
         end
      end
   end

   // cross term for axis j: n[j+1]*w[j+2] - n[j+2]*w[j+1], indexes mod 3
   always_comb begin
      case (cmd.mac_axis)
         AXIS_X:  begin ia = AXIS_Y; ic = AXIS_Z; end
         AXIS_Y:  begin ia = AXIS_Z; ic = AXIS_X; end
         AXIS_Z:  begin ia = AXIS_X; ic = AXIS_Y; end
         default: begin ia = AXIS_X; ic = AXIS_Y; end
      endcase
      na = n_ff[cmd.mac_layer][ia];
      nc = n_ff[cmd.mac_layer][ic];
      nsel = cmd.mac_part[1] ? nc : na;
      wsel = cmd.mac_part[1] ? omega_ff[ia] : omega_ff[ic];
      case (cmd.mac_part)
         PART_AB_HI, PART_CD_HI: mop = nsel[N_W-1:16];
         PART_AB_LO, PART_CD_LO: mop = {{(MOP_W-16){1'b0}}, nsel[15:0]};
         default:                mop = '0;
      endcase
   end

   assign prod_in = mop * wsel;

   // high partials weigh 2^16, second product is subtracted
   assign term = prod_shift_ff ? {{(ACC_W-PROD_W-16){prod_ff[PROD_W-1]}}, prod_ff, 16'b0}
                               : ACC_W'(prod_ff);
   assign acc_base = prod_first_ff ? '0 : acc_ff;
   assign acc_in   = prod_sub_ff ? acc_base - term : acc_base + term;

   // round to nearest, ties up, over 2^19, then clamp to 32 bits
   assign biased = acc_ff + ROUND_BIAS;
   assign shr    = biased[ACC_W-1:19];
   always_comb begin
      if (&shr[SHR_W-1:DATA_W-1] || ~|shr[SHR_W-1:DATA_W-1]) begin
         sat = shr[DATA_W-1:0];
      end else if (shr[SHR_W-1]) begin
         sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_en) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            n_ff[0][a] <= n1_in[a];
            n_ff[1][a] <= n2_in[a];
         end
      end
      if (cmd.mac_en) begin
         prod_ff       <= prod_in;
         prod_shift_ff <= ~cmd.mac_part[0];
         prod_sub_ff   <= cmd.mac_part[1];
         prod_first_ff <= (cmd.mac_part == PART_AB_HI);
         prod_last_ff  <= (cmd.mac_part == PART_CD_LO);
         prod_layer_ff <= cmd.mac_layer;
         prod_axis_ff  <= cmd.mac_axis;
      end
      if (prod_valid_ff) begin
         acc_ff       <= acc_in;
         rnd_layer_ff <= prod_layer_ff;
         rnd_axis_ff  <= prod_axis_ff;
      end
      if (rnd_valid_ff) begin
         res_ff[rnd_layer_ff][rnd_axis_ff] <= sat;
      end
   end

   assign rsp_ghost_layer  = cmd.emit_layer;
   assign rsp_last_of_cell = cmd.emit_layer;
   assign rsp_delta_u      = res_ff[cmd.emit_layer][0];
   assign rsp_delta_v      = res_ff[cmd.emit_layer][1];
   assign rsp_delta_w      = res_ff[cmd.emit_layer][2];

endmodule
